// ===== hw/rtl/mwkt_pkg.sv =====
package mwkt_pkg;

	localparam int unsigned CHANNELS_DEF = 8;
	localparam logic [31:0] MIN_PERIOD_DEF = 32'd1;
	localparam logic [31:0] MAX_PERIOD_DEF = 32'd65535;

	// x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
	localparam logic [31:0] DIV_MAGIC = 32'h10624DD3;
	localparam int unsigned DIV_SHIFT = 38;

	typedef enum logic [2:0] {
		CMD_INIT   = 3'd0,
		CMD_DEINIT = 3'd1,
		CMD_START  = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_SETP   = 3'd4,
		CMD_GET    = 3'd5,
		CMD_TICK   = 3'd6
	} cmd_e;

	typedef enum logic [2:0] {
		CFG_NUM_CHANNELS = 3'd0,
		CFG_CONF_MASK    = 3'd1,
		CFG_ONESHOT_MASK = 3'd2,
		CFG_TICK_FREQ    = 3'd3,
		CFG_INIT_PERIOD  = 3'd4
	} cfg_idx_e;

	typedef enum logic [1:0] {
		MODE_UNINIT  = 2'd0,
		MODE_READY   = 2'd1,
		MODE_RUNNING = 2'd2,
		MODE_STOPPED = 2'd3
	} mode_t;

	localparam logic [2:0] CST_UNINIT = 3'd0;
	localparam logic [2:0] CST_ERROR  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EXEC,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  channel;
		logic [31:0] period_ms;
		logic        watchdog_ok;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [2:0]  chan_state;
		logic        trigger;
		logic        trigger_ok;
		logic [31:0] kick_total;
		logic [31:0] missed_total;
	} res_t;

	typedef struct packed {
		logic [3:0]  num_channels;
		logic [7:0]  configured_mask;
		logic [7:0]  one_shot_mask;
		logic [31:0] tick_freq_hz;
		logic [31:0] init_period_ms;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] tick;
		logic [31:0] target;
		logic [31:0] kick;
		logic [31:0] miss;
	} entry_t;

endpackage

// ===== hw/rtl/multichannel_watchdog_kick_timer_top.sv =====
// A taken start goes to exec, via conv first for init and set period; result and done are
// registered at the end of exec. The entry is read when start is taken, written back in exec;
// starts are taken only while idle, and init and deinit then hold busy to rewrite all entries.
// Reset: arst_n clears the controller and per-entry valid bits; every channel reads uninit.
// The receiver cannot stall: done marks each result beat for exactly one cycle.
module multichannel_watchdog_kick_timer_top import mwkt_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF,
	parameter logic [31:0] MIN_PERIOD_MS = MIN_PERIOD_DEF,
	parameter logic [31:0] MAX_PERIOD_MS = MAX_PERIOD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        command,
	output logic        busy,
	output logic        done,
	output res_t        result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t cfg_q;
	logic rd_en, wr_en, conv_load;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t rd_data, wr_data;
	logic [31:0] conv_ms, conv_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_channels <= 4'd0;
			cfg_q.configured_mask <= 8'd0;
			cfg_q.one_shot_mask <= 8'd0;
			cfg_q.tick_freq_hz <= 32'd1000;
			cfg_q.init_period_ms <= 32'd100;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NUM_CHANNELS: cfg_q.num_channels <= cfg_data[3:0];
				CFG_CONF_MASK:    cfg_q.configured_mask <= cfg_data[7:0];
				CFG_ONESHOT_MASK: cfg_q.one_shot_mask <= cfg_data[7:0];
				CFG_TICK_FREQ:    cfg_q.tick_freq_hz <= cfg_data;
				CFG_INIT_PERIOD:  cfg_q.init_period_ms <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mwkt_mem #(
		.CHANNELS(CHANNELS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	mwkt_conv u_conv (
		.clk(clk),
		.load(conv_load),
		.ms(conv_ms),
		.freq(cfg_q.tick_freq_hz),
		.ticks(conv_ticks)
	);

	mwkt_ctrl #(
		.CHANNELS(CHANNELS),
		.MIN_PERIOD_MS(MIN_PERIOD_MS),
		.MAX_PERIOD_MS(MAX_PERIOD_MS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.cfg(cfg_q),
		.busy(busy),
		.done(done),
		.result(result),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.conv_load(conv_load),
		.conv_ms(conv_ms),
		.conv_ticks(conv_ticks)
	);

endmodule

// ===== hw/rtl/mwkt_mem.sv =====
module mwkt_mem import mwkt_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF,
	parameter int unsigned AW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	entry_t data_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? data_q : '0;

endmodule

// ===== hw/rtl/mwkt_conv.sv =====
module mwkt_conv import mwkt_pkg::*; (
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] ms,
	input  logic [31:0] freq,
	output logic [31:0] ticks
);

	logic [31:0] prod_s1;
	logic fz_s1;
	logic [63:0] recip;
	logic [25:0] quot;
	logic [31:0] ticks_s2;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= 32'(ms * freq);
			fz_s1 <= (freq == 32'd0);
		end
	end

	assign recip = 64'(prod_s1) * 64'(DIV_MAGIC);
	assign quot = recip[63:DIV_SHIFT];

	always_ff @(posedge clk) begin
		if (fz_s1) begin
			ticks_s2 <= 32'd0;
		end else if (quot == 26'd0) begin
			ticks_s2 <= 32'd1;
		end else begin
			ticks_s2 <= {6'd0, quot};
		end
	end

	assign ticks = ticks_s2;

endmodule

// ===== hw/rtl/mwkt_ctrl.sv =====
module mwkt_ctrl import mwkt_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF,
	parameter logic [31:0] MIN_PERIOD_MS = MIN_PERIOD_DEF,
	parameter logic [31:0] MAX_PERIOD_MS = MAX_PERIOD_DEF,
	parameter int unsigned AW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmd_t          command,
	input  cfg_t          cfg,
	output logic          busy,
	output logic          done,
	output res_t          result,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  entry_t        rd_data,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data,
	output logic          conv_load,
	output logic [31:0]   conv_ms,
	input  logic [31:0]   conv_ticks
);

	localparam logic [AW-1:0] LAST = AW'(CHANNELS - 1);

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic init_q, init_d;
	logic fill_q;
	logic [AW-1:0] idx_q;
	res_t res_q, res_d;
	logic done_q;

	logic accept;
	logic valid, conf_ch, pok, iok, init_go, init_good, any_conf;
	logic sweep, fill, fail, trig, ex_wr;
	logic [7:0] conf_vec;
	logic [31:0] tnext;
	entry_t ent, nent, oent;

	function automatic logic command_valid(input logic [7:0] ch);
		return {24'd0, ch} < 32'(CHANNELS);
	endfunction

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			conf_vec[c] = (4'(c) < cfg.num_channels) && (c < CHANNELS) &&
				cfg.configured_mask[c];
		end
	end

	assign any_conf = |conf_vec;
	assign valid = command_valid(cmd_q.channel);
	assign conf_ch = valid && conf_vec[cmd_q.channel[2:0]];
	assign pok = (cmd_q.period_ms >= MIN_PERIOD_MS) && (cmd_q.period_ms <= MAX_PERIOD_MS);
	assign iok = (cfg.init_period_ms >= MIN_PERIOD_MS) &&
		(cfg.init_period_ms <= MAX_PERIOD_MS);
	assign init_go = !init_q && ({28'd0, cfg.num_channels} <= 32'(CHANNELS));
	assign init_good = init_go && (!any_conf || iok);
	assign ent = rd_data;
	assign tnext = ent.tick + 32'd1;

	always_comb begin
		nent = ent;
		fail = 1'b1;
		trig = 1'b0;
		init_d = init_q;
		ex_wr = 1'b0;
		sweep = 1'b0;
		fill = 1'b0;
		case (cmd_q.cmd)
			CMD_INIT: begin
				if (init_go) begin
					sweep = 1'b1;
					fill = init_good;
					fail = !init_good;
					init_d = init_good;
				end
			end
			CMD_DEINIT: begin
				if (init_q) begin
					sweep = 1'b1;
					fail = 1'b0;
					init_d = 1'b0;
				end
			end
			CMD_START: begin
				if (init_q && conf_ch) begin
					if (ent.mode == MODE_RUNNING) begin
						fail = 1'b0;
					end else if (ent.mode == MODE_READY || ent.mode == MODE_STOPPED) begin
						nent.tick = 32'd0;
						nent.mode = MODE_RUNNING;
						ex_wr = 1'b1;
						fail = 1'b0;
					end
				end
			end
			CMD_STOP: begin
				if (init_q && valid) begin
					if (ent.mode == MODE_RUNNING) begin
						nent.mode = MODE_STOPPED;
						ex_wr = 1'b1;
					end
					fail = 1'b0;
				end
			end
			CMD_SETP: begin
				if (init_q && pok && conf_ch) begin
					nent.target = conv_ticks;
					nent.tick = 32'd0;
					ex_wr = 1'b1;
					fail = 1'b0;
				end
			end
			CMD_GET: begin
				if (init_q && valid) begin
					fail = 1'b0;
				end
			end
			CMD_TICK: begin
				if (init_q && valid && ent.mode == MODE_RUNNING) begin
					fail = 1'b0;
					ex_wr = 1'b1;
					nent.tick = tnext;
					if (tnext >= ent.target) begin
						nent.tick = 32'd0;
						if (conf_ch) begin
							trig = 1'b1;
							if (cmd_q.watchdog_ok) begin
								nent.kick = ent.kick + 32'd1;
							end else begin
								nent.miss = ent.miss + 32'd1;
							end
							if (cfg.one_shot_mask[cmd_q.channel[2:0]]) begin
								nent.mode = MODE_STOPPED;
							end
						end
					end
				end
			end
			default: begin
				fail = 1'b1;
			end
		endcase
	end

	always_comb begin
		oent = nent;
		if (sweep) begin
			oent = '0;
			if (fill && conf_ch) begin
				oent.mode = MODE_READY;
			end
		end
		res_d.status = fail;
		if (!init_d) begin
			res_d.chan_state = CST_UNINIT;
		end else if (!valid) begin
			res_d.chan_state = CST_ERROR;
		end else begin
			res_d.chan_state = {1'b0, oent.mode};
		end
		res_d.trigger = trig;
		res_d.trigger_ok = trig && cmd_q.watchdog_ok;
		res_d.kick_total = valid ? oent.kick : 32'd0;
		res_d.missed_total = valid ? oent.miss : 32'd0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command.cmd == CMD_INIT || command.cmd == CMD_SETP) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_CONV: state_d = ST_EXEC;
			ST_EXEC: state_d = sweep ? ST_SWEEP : ST_IDLE;
			ST_SWEEP: begin
				if (idx_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		rd_en = accept;
		rd_addr = command.channel[AW-1:0];
		conv_load = accept;
		conv_ms = (command.cmd == CMD_INIT) ? cfg.init_period_ms : command.period_ms;
		wr_en = 1'b0;
		wr_addr = cmd_q.channel[AW-1:0];
		wr_data = nent;
		case (state_q)
			ST_EXEC: begin
				wr_en = ex_wr;
			end
			ST_SWEEP: begin
				wr_en = 1'b1;
				wr_addr = idx_q;
				wr_data = '0;
				if (fill_q && conf_vec[3'(idx_q)]) begin
					wr_data.mode = MODE_READY;
					wr_data.target = conv_ticks;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
		end
		if (state_q == ST_EXEC) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_q <= 1'b0;
			fill_q <= 1'b0;
			idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_EXEC);
			if (state_q == ST_EXEC) begin
				init_q <= init_d;
				fill_q <= fill;
				idx_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");
	a_ok_needs_trig: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.trigger_ok |-> result.trigger) else $error("trigger_ok without trigger");
	a_trig_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.trigger |-> !result.status) else $error("trigger on failed tick");
	a_uninit_state: assert property (@(posedge clk) disable iff (!arst_n)
		done && !init_q |-> result.chan_state == CST_UNINIT)
		else $error("channel state shown while uninitialized");

endmodule
